>>> design/piq_pkg.sv
// Shared types and codes for the positional insert queue.
// Used by the top level and its port checker; no dependencies.
`default_nettype none

package piq_pkg;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned ENTRY_W = TAG_W + 2 * VAL_W;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned OCC_W   = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> design/piq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module piq_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> design/positional_insert_queue.sv
// Positional insert queue: top level with a small sequencer over one RAM.
// Depends on piq_pkg and piq_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per item: an
//   insert at a 1-based position (0 or 1 means head, beyond occupancy means
//   tail) or a pop of the head entry. Output channel (o_out_valid /
//   i_out_stall) returns exactly one beat per item: status, popped entry
//   (zero unless popped) and occupancy after the item.
//   Entries live in a circular buffer with head and tail pointers. An insert
//   at slot s with occupancy c moves c - s entries one place toward the tail,
//   one entry per cycle through the single RAM read and write port.
//   An empty pop or a dropped insert goes straight to the final step; a pop
//   first takes the head entry (S_POP), an insert first shifts (S_SHIFT, when
//   anything moves) and writes the new entry (S_WRITE). o_in_stall stays
//   high from accept until the sequencer is back idle. The sequencer holds
//   in its final step while i_out_stall keeps the output register occupied.
//   Reset empties the queue at once (count, head and tail cleared, RAM content
//   left as is) and drops any pending result.
`default_nettype none

module positional_insert_queue #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [piq_pkg::POS_W-1:0]     i_position,
    input  wire logic [piq_pkg::TAG_W-1:0]     i_entry_tag,
    input  wire logic [piq_pkg::VAL_W-1:0]     i_first_value,
    input  wire logic [piq_pkg::VAL_W-1:0]     i_second_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output piq_pkg::t_status                   o_status,
    output logic      [piq_pkg::TAG_W-1:0]     o_out_tag,
    output logic      [piq_pkg::VAL_W-1:0]     o_out_first,
    output logic      [piq_pkg::VAL_W-1:0]     o_out_second,
    output logic      [piq_pkg::OCC_W-1:0]     o_occupancy
);

    import piq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_POP,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_head;
    logic [AW-1:0]        r_tail;
    logic [AW-1:0]        r_rd_ptr;
    logic [AW-1:0]        r_wr_ptr;
    logic [CW-1:0]        r_left;
    logic                 r_pend;
    logic [ENTRY_W-1:0]   r_entry;
    logic [ENTRY_W-1:0]   r_pop;
    t_status              r_status;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ENTRY_W-1:0]   r_out_entry;
    logic [OCC_W-1:0]     r_out_occ;

    logic                 in_accept;
    logic                 out_free;
    logic                 full;
    logic [SW-1:0]        slot_raw;
    logic [CW-1:0]        slot;
    logic [CW-1:0]        moves;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [ENTRY_W-1:0]   ram_rd_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = (r_count == CW'(DEPTH));

    always_comb begin
        slot_raw = (i_position <= POS_W'(1)) ? '0 : SW'(i_position - POS_W'(1));
        slot     = (slot_raw > SW'(r_count)) ? r_count : CW'(slot_raw);
        moves    = r_count - slot;
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_ptr;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = r_head;
        case (r_state)
            S_SHIFT: begin
                ram_wr_en   = r_pend;
                ram_rd_addr = r_rd_ptr;
            end
            S_WRITE: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = r_entry;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    piq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_entry <= {i_entry_tag, i_first_value, i_second_value};
                        r_pop   <= '0;
                        r_pend  <= 1'b0;
                        if (i_action == ACT_POP) begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_POP;
                            end
                        end else if (full) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_rd_ptr <= ptr_dec(r_tail);
                            r_wr_ptr <= r_tail;
                            r_left   <= moves;
                            r_state  <= (moves == '0) ? S_WRITE : S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_pend) begin
                        r_wr_ptr <= ptr_dec(r_wr_ptr);
                    end
                    if (r_left != '0) begin
                        r_rd_ptr <= ptr_dec(r_rd_ptr);
                        r_left   <= r_left - CW'(1);
                        r_pend   <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count  <= r_count + CW'(1);
                    r_tail   <= ptr_inc(r_tail);
                    r_status <= ST_INSERTED;
                    r_state  <= S_DONE;
                end
                S_POP: begin
                    r_pop    <= ram_rd_data;
                    r_count  <= r_count - CW'(1);
                    r_head   <= ptr_inc(r_head);
                    r_status <= ST_POPPED;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_entry  <= r_pop;
                        r_out_occ    <= OCC_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_out_tag    = r_out_entry[ENTRY_W-1 -: TAG_W];
    assign o_out_first  = r_out_entry[2*VAL_W-1 -: VAL_W];
    assign o_out_second = r_out_entry[VAL_W-1:0];
    assign o_occupancy  = r_out_occ;

endmodule

`default_nettype wire

>>> design/piq_checker.sv
// Port-level checker for the positional insert queue, bound to the top level.
// Depends on piq_pkg.
`default_nettype none

module piq_checker #(
    parameter int unsigned DEPTH = 64
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire piq_pkg::t_status              o_status,
    input wire logic [piq_pkg::TAG_W-1:0]     o_out_tag,
    input wire logic [piq_pkg::VAL_W-1:0]     o_out_first,
    input wire logic [piq_pkg::VAL_W-1:0]     o_out_second,
    input wire logic [piq_pkg::OCC_W-1:0]     o_occupancy
);

    import piq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_out_tag) && $stable(o_occupancy))
        else $error("stalled result beat changed");

    // one item at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_occupancy == '0 && o_out_tag == '0 && o_out_first == '0
            && o_out_second == '0)
        else $error("empty pop with data or nonzero occupancy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |->
            o_occupancy == OCC_W'(DEPTH) && o_out_tag == '0)
        else $error("dropped insert with wrong occupancy");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_INSERTED |->
            o_occupancy != '0 && o_out_tag == '0 && o_out_first == '0)
        else $error("insert result inconsistent");

endmodule

bind positional_insert_queue piq_checker #(
    .DEPTH (DEPTH)
) u_piq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_out_tag    (o_out_tag),
    .o_out_first  (o_out_first),
    .o_out_second (o_out_second),
    .o_occupancy  (o_occupancy)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for positional_insert_queue: directed and random
// inserts and pops, checked beat by beat against an in-bench queue predictor.
// Depends on piq_pkg and the positional_insert_queue RTL.
`timescale 1ns / 100ps

module tb;
    import piq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int LIMIT      = 400000;
    localparam int RANDOM_CNT = 400;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] first;
        logic [VAL_W-1:0] second;
    } t_entry;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] first;
        logic [VAL_W-1:0] second;
        logic [OCC_W-1:0] occ;
    } t_result;

    class queue_scoreboard;
        t_entry  held[$];
        t_result expected_q[$];
        int      errors;
        int      checked;
        int      full_drops;
        int      empty_pops;
        int      peak;

        function void note_item(logic act, logic [POS_W-1:0] pos, t_entry e);
            t_result r;
            int      slot;
            r = '0;
            if (act == ACT_INSERT) begin
                if (held.size() >= DEPTH) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    slot = (pos <= 1) ? 0 : int'(pos) - 1;
                    if (slot > held.size()) slot = held.size();
                    held.insert(slot, e);
                    r.status = ST_INSERTED;
                end
            end else begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    r.tag    = held[0].tag;
                    r.first  = held[0].first;
                    r.second = held[0].second;
                    void'(held.pop_front());
                    r.status = ST_POPPED;
                end
            end
            if (held.size() > peak) peak = held.size();
            r.occ = OCC_W'(held.size());
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: status=%0d tag=%h first=%h second=%h occ=%0d",
                             int'(got.status), got.tag, got.first, got.second, got.occ);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status || got.tag !== want.tag ||
                got.first !== want.first || got.second !== want.second ||
                got.occ !== want.occ) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch on beat %0d: expected status=%0d tag=%h first=%h %s",
                             checked, int'(want.status), want.tag, want.first, "");
                    $display("    expected second=%h occ=%0d", want.second, want.occ);
                    $display("    got status=%0d tag=%h first=%h second=%h occ=%0d",
                             int'(got.status), got.tag, got.first, got.second, got.occ);
                end
            end
        endfunction

        function int count();
            return held.size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               i_action       = ACT_INSERT;
    logic [POS_W-1:0]   i_position     = '0;
    logic [TAG_W-1:0]   i_entry_tag    = '0;
    logic [VAL_W-1:0]   i_first_value  = '0;
    logic [VAL_W-1:0]   i_second_value = '0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_status            o_status;
    logic [TAG_W-1:0]   o_out_tag;
    logic [VAL_W-1:0]   o_out_first;
    logic [VAL_W-1:0]   o_out_second;
    logic [OCC_W-1:0]   o_occupancy;

    queue_scoreboard sb;
    int              cycle_count = 0;
    int              items_sent  = 0;
    bit              in_quiet    = 1'b0;
    bit              out_quiet   = 1'b0;

    positional_insert_queue #(.DEPTH(DEPTH)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_entry_tag    (i_entry_tag),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_occupancy    (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_entry rand_entry();
        t_entry e;
        e.tag    = TAG_W'($urandom_range(0, 65535));
        e.first  = VAL_W'($urandom_range(0, 65535));
        e.second = VAL_W'($urandom_range(0, 65535));
        return e;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int cnt);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return POS_W'(1);
            2: return POS_W'($urandom_range(2, cnt + 1));
            3: return POS_W'(cnt + 1);
            4: return POS_W'($urandom_range((cnt + 2 > 255) ? 255 : cnt + 2, 255));
            default: return POS_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [POS_W-1:0] pos, input t_entry e);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_position     <= pos;
        i_entry_tag    <= e.tag;
        i_first_value  <= e.first;
        i_second_value <= e.second;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(act, pos, e);
        items_sent++;
    endtask

    task automatic send_insert(input logic [POS_W-1:0] pos, input t_entry e);
        send_item(ACT_INSERT, pos, e);
    endtask

    task automatic send_pop();
        send_item(ACT_POP, POS_W'($urandom_range(0, 255)), rand_entry());
    endtask

    // receive side: random stall before each beat, quiet stretches now and then
    initial begin
        int      gap;
        t_result got;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) out_quiet = ~out_quiet;
            gap = out_quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.status = o_status;
            got.tag    = o_out_tag;
            got.first  = o_out_first;
            got.second = o_out_second;
            got.occ    = o_occupancy;
            sb.check_result(got);
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int     left;
        int     seg_len;
        int     kind;
        int     pct;
        t_entry e;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, head/tail/middle positions, field extremes, drain
        send_pop();
        send_insert(POS_W'(0), rand_entry());
        send_insert(POS_W'(1), rand_entry());
        send_insert(POS_W'(255), rand_entry());
        send_insert(POS_W'(2), rand_entry());
        send_insert(POS_W'(5), rand_entry());
        send_insert(POS_W'(5), rand_entry());
        e = '1;
        send_insert(POS_W'(3), e);
        e = '0;
        send_insert(POS_W'(200), e);
        e.tag = 16'h8001; e.first = 16'h7ffe; e.second = 16'h5aa5;
        send_insert(POS_W'(128), e);
        repeat (10) send_pop();
        send_pop();

        // fill to capacity, then overflow a few times
        in_quiet = 1'b1;
        while (sb.count() < DEPTH) send_insert(pick_position(sb.count()), rand_entry());
        repeat (3) send_insert(pick_position(sb.count()), rand_entry());
        in_quiet = 1'b0;

        left = RANDOM_CNT;
        while (left > 0) begin
            kind     = $urandom_range(0, 2);
            seg_len  = $urandom_range(20, 80);
            in_quiet = ($urandom_range(0, 3) == 0);
            pct      = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
            for (int i = 0; i < seg_len && left > 0; i++) begin
                if ($urandom_range(1, 100) <= pct)
                    send_insert(pick_position(sb.count()), rand_entry());
                else
                    send_pop();
                left--;
            end
        end
        while (sb.count() > 0) send_pop();
        send_pop();

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("run covered %0d items, %0d result beats checked, peak occupancy %0d",
                 items_sent, sb.checked, sb.peak);
        $display("full drops %0d, empty pops %0d, failures %0d",
                 sb.full_drops, sb.empty_pops, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/piq_pkg.sv
design/piq_ram.sv
design/positional_insert_queue.sv
design/piq_checker.sv
dv/tb.sv
